// ===== design/irs_pkg.sv =====
// Types and constants shared by the hose-reel irrigation sequencer.
// Needed by irs_step and irrigation_reel_sequencer_unit; depends on nothing.
package irs_pkg;

    // state machine constants
    localparam logic [4:0]  STABLE_TICKS       = 5'd30;
    localparam logic [1:0]  MAX_ATTEMPTS       = 2'd2;
    localparam logic [15:0] FIRST_FILL_TIMEOUT = 16'd200;

    // request opcodes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_STOP      = 3'd1;
    localparam logic [2:0] OP_RESET     = 3'd2;
    localparam logic [2:0] OP_CANNON    = 3'd3;
    localparam logic [2:0] OP_RESERVOIR = 3'd4;
    localparam logic [2:0] OP_EMERGENCY = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_START_DELAY   = 3'd0;
    localparam logic [2:0] CFG_ARRIVAL_DELAY = 3'd1;
    localparam logic [2:0] CFG_DRAIN         = 3'd2;
    localparam logic [2:0] CFG_FILL_TIMEOUT  = 3'd3;
    localparam logic [2:0] CFG_TIMED_FILL    = 3'd4;
    localparam logic [2:0] CFG_PROGRAM_VALID = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_OPEN   = 4'd1,
        ST_SDELAY = 4'd2,
        ST_FIRST  = 4'd3,
        ST_RUN    = 4'd4,
        ST_PAUSE  = 4'd5,
        ST_ARRIVE = 4'd6,
        ST_FINAL  = 4'd7,
        ST_EMERG  = 4'd8
    } irs_main_t;

    typedef enum logic [1:0] {
        SUB_DRAIN = 2'd0,
        SUB_WAIT  = 2'd1,
        SUB_FILL  = 2'd2
    } irs_sub_t;

    typedef enum logic [1:0] {
        CAUSE_NONE         = 2'd0,
        CAUSE_FIRST_FILL   = 2'd1,
        CAUSE_FILL_TIMEOUT = 2'd2,
        CAUSE_EXTERNAL     = 2'd3
    } irs_cause_t;

    typedef struct packed {
        logic [15:0] start_delay_ticks;
        logic [15:0] arrival_delay_ticks;
        logic [15:0] drain_ticks;
        logic [15:0] fill_timeout_ticks;
        logic        timed_fill_mode;
        logic        program_valid;
    } irs_cfg_t;

    typedef struct packed {
        irs_main_t   main_state;
        irs_sub_t    sub_state;
        logic [15:0] state_ticks;
        logic [15:0] sub_ticks;
        logic [4:0]  stable_count;
        logic [1:0]  attempt_count;
        logic [15:0] wait_len;
        logic [15:0] fill_len;
        logic [31:0] pause_ticks;
        logic        cannon_valve;
        logic        reservoir_valve;
        irs_cause_t  cause;
    } irs_state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        pressure_ok;
        logic        end_of_travel;
        logic        reservoir_full;
        logic [15:0] next_wait_ticks;
        logic        valve_on;
    } irs_in_t;

    typedef struct packed {
        logic [3:0]  main_state_out;
        logic [1:0]  sub_state_out;
        logic        cannon_valve_out;
        logic        reservoir_valve_out;
        logic [1:0]  emergency_cause;
        logic [15:0] last_fill_ticks;
        logic [31:0] pause_total_ticks;
    } irs_out_t;

    localparam irs_cfg_t CFG_RESET = '{
        start_delay_ticks:   16'd0,
        arrival_delay_ticks: 16'd0,
        drain_ticks:         16'd50,
        fill_timeout_ticks:  16'd200,
        timed_fill_mode:     1'b0,
        program_valid:       1'b0
    };

    localparam irs_state_t STATE_RESET = '{
        main_state:      ST_IDLE,
        sub_state:       SUB_DRAIN,
        state_ticks:     16'd0,
        sub_ticks:       16'd0,
        stable_count:    5'd0,
        attempt_count:   2'd0,
        wait_len:        16'd0,
        fill_len:        16'd0,
        pause_ticks:     32'd0,
        cannon_valve:    1'b0,
        reservoir_valve: 1'b0,
        cause:           CAUSE_NONE
    };

endpackage

// ===== design/irs_step.sv =====
// Next-state and result logic for one request of the irrigation sequencer.
// Purely combinational; uses irs_pkg for the state, config and payload types.
module irs_step
    import irs_pkg::*;
(
    input  irs_cfg_t   cfg,
    input  irs_state_t state_cur,
    input  irs_in_t    item,
    output irs_state_t state_next,
    output irs_out_t   result
);

    irs_state_t  nx;
    logic [15:0] drain_lim;
    logic [15:0] fill_lim;
    logic        fill_done;

    always_comb begin
        nx        = state_cur;
        drain_lim = (cfg.drain_ticks == 16'd0) ? 16'd1 : cfg.drain_ticks;
        fill_lim  = (cfg.fill_timeout_ticks == 16'd0) ? FIRST_FILL_TIMEOUT
                                                       : cfg.fill_timeout_ticks;
        fill_done = 1'b0;

        unique case (item.op)
            OP_TICK: begin
                if (state_cur.state_ticks != 16'hFFFF) begin
                    nx.state_ticks = state_cur.state_ticks + 16'd1;
                end
                if (state_cur.sub_ticks != 16'hFFFF) begin
                    nx.sub_ticks = state_cur.sub_ticks + 16'd1;
                end

                unique case (state_cur.main_state)
                    ST_IDLE: begin
                        if (item.pressure_ok && !item.end_of_travel && cfg.program_valid) begin
                            nx.cannon_valve = 1'b1;
                            nx.stable_count = 5'd0;
                            nx.main_state   = ST_OPEN;
                            nx.state_ticks  = 16'd0;
                        end
                    end
                    ST_OPEN: begin
                        if (item.pressure_ok) begin
                            if (state_cur.stable_count != 5'd31) begin
                                nx.stable_count = state_cur.stable_count + 5'd1;
                            end
                        end else begin
                            nx.stable_count = 5'd0;
                        end
                        if (nx.stable_count >= STABLE_TICKS) begin
                            nx.stable_count = 5'd0;
                            nx.pause_ticks  = 32'd0;
                            nx.state_ticks  = 16'd0;
                            if (cfg.start_delay_ticks != 16'd0) begin
                                nx.main_state = ST_SDELAY;
                            end else begin
                                nx.reservoir_valve = 1'b1;
                                nx.attempt_count   = 2'd0;
                                nx.main_state      = ST_FIRST;
                            end
                        end
                    end
                    ST_SDELAY: begin
                        if (!item.pressure_ok) begin
                            nx.cannon_valve = 1'b0;
                            nx.main_state   = ST_PAUSE;
                            nx.state_ticks  = 16'd0;
                        end else if (nx.state_ticks >= cfg.start_delay_ticks) begin
                            nx.reservoir_valve = 1'b1;
                            nx.attempt_count   = 2'd0;
                            nx.main_state      = ST_FIRST;
                            nx.state_ticks     = 16'd0;
                        end
                    end
                    ST_FIRST: begin
                        if (!item.pressure_ok) begin
                            nx.cannon_valve    = 1'b0;
                            nx.reservoir_valve = 1'b0;
                            nx.main_state      = ST_PAUSE;
                            nx.state_ticks     = 16'd0;
                        end else if (item.reservoir_full) begin
                            nx.reservoir_valve = 1'b0;
                            nx.cannon_valve    = 1'b1;
                            nx.attempt_count   = 2'd0;
                            nx.main_state      = ST_RUN;
                            nx.state_ticks     = 16'd0;
                            nx.sub_state       = SUB_DRAIN;
                            nx.sub_ticks       = 16'd0;
                        end else if (nx.state_ticks >= FIRST_FILL_TIMEOUT) begin
                            if (state_cur.attempt_count != 2'd3) begin
                                nx.attempt_count = state_cur.attempt_count + 2'd1;
                            end
                            nx.state_ticks = 16'd0;
                            if (nx.attempt_count >= MAX_ATTEMPTS) begin
                                nx.cannon_valve    = 1'b0;
                                nx.reservoir_valve = 1'b0;
                                nx.main_state      = ST_EMERG;
                                nx.cause           = CAUSE_FIRST_FILL;
                            end else begin
                                // retry: valve reopened, timer restarted
                                nx.reservoir_valve = 1'b1;
                            end
                        end
                    end
                    ST_RUN: begin
                        if (!item.pressure_ok) begin
                            nx.cannon_valve    = 1'b0;
                            nx.reservoir_valve = 1'b0;
                            nx.main_state      = ST_PAUSE;
                            nx.state_ticks     = 16'd0;
                        end else if (item.end_of_travel) begin
                            nx.reservoir_valve = 1'b0;
                            nx.state_ticks     = 16'd0;
                            if (cfg.arrival_delay_ticks != 16'd0) begin
                                nx.main_state = ST_ARRIVE;
                            end else begin
                                nx.cannon_valve = 1'b0;
                                nx.main_state   = ST_FINAL;
                            end
                        end else begin
                            unique case (state_cur.sub_state)
                                SUB_DRAIN: begin
                                    if (nx.sub_ticks >= drain_lim) begin
                                        nx.sub_state = SUB_WAIT;
                                        nx.sub_ticks = 16'd0;
                                    end
                                end
                                SUB_WAIT: begin
                                    if (nx.sub_ticks >= state_cur.wait_len) begin
                                        nx.reservoir_valve = 1'b1;
                                        nx.sub_state       = SUB_FILL;
                                        nx.sub_ticks       = 16'd0;
                                    end
                                end
                                SUB_FILL: begin
                                    if (cfg.timed_fill_mode) begin
                                        fill_done = (nx.sub_ticks >= fill_lim);
                                    end else if (item.reservoir_full) begin
                                        fill_done = 1'b1;
                                    end else if (nx.sub_ticks >= fill_lim) begin
                                        if (state_cur.attempt_count != 2'd3) begin
                                            nx.attempt_count = state_cur.attempt_count + 2'd1;
                                        end
                                        if (nx.attempt_count >= MAX_ATTEMPTS) begin
                                            nx.cannon_valve    = 1'b0;
                                            nx.reservoir_valve = 1'b0;
                                            nx.main_state      = ST_EMERG;
                                            nx.state_ticks     = 16'd0;
                                            nx.cause           = CAUSE_FILL_TIMEOUT;
                                        end else begin
                                            nx.reservoir_valve = 1'b0;
                                            nx.sub_state       = SUB_DRAIN;
                                            nx.sub_ticks       = 16'd0;
                                        end
                                    end
                                    if (fill_done) begin
                                        nx.reservoir_valve = 1'b0;
                                        nx.fill_len        = nx.sub_ticks;
                                        nx.wait_len        = item.next_wait_ticks;
                                        nx.attempt_count   = 2'd0;
                                        nx.sub_state       = SUB_DRAIN;
                                        nx.sub_ticks       = 16'd0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    ST_PAUSE: begin
                        if (state_cur.pause_ticks != 32'hFFFF_FFFF) begin
                            nx.pause_ticks = state_cur.pause_ticks + 32'd1;
                        end
                        if (item.pressure_ok) begin
                            nx.cannon_valve = 1'b1;
                            nx.main_state   = ST_RUN;
                            nx.state_ticks  = 16'd0;
                            nx.sub_state    = SUB_DRAIN;
                            nx.sub_ticks    = 16'd0;
                        end
                    end
                    ST_ARRIVE: begin
                        if (!item.pressure_ok || nx.state_ticks >= cfg.arrival_delay_ticks) begin
                            nx.cannon_valve = 1'b0;
                            nx.main_state   = ST_FINAL;
                            nx.state_ticks  = 16'd0;
                        end
                    end
                    ST_FINAL: begin
                        if (!item.end_of_travel) begin
                            nx.cause       = CAUSE_NONE;
                            nx.main_state  = ST_IDLE;
                            nx.state_ticks = 16'd0;
                        end
                    end
                    default: ;
                endcase
            end
            OP_STOP: begin
                if (state_cur.main_state != ST_IDLE && state_cur.main_state != ST_FINAL &&
                    state_cur.main_state != ST_EMERG) begin
                    nx.cannon_valve    = 1'b0;
                    nx.reservoir_valve = 1'b0;
                    nx.main_state      = ST_FINAL;
                    nx.state_ticks     = 16'd0;
                end
            end
            OP_RESET: begin
                if (state_cur.main_state == ST_EMERG) begin
                    nx.cause       = CAUSE_NONE;
                    nx.main_state  = ST_IDLE;
                    nx.state_ticks = 16'd0;
                end
            end
            OP_CANNON: begin
                if (state_cur.main_state == ST_IDLE) nx.cannon_valve = item.valve_on;
            end
            OP_RESERVOIR: begin
                if (state_cur.main_state == ST_IDLE) nx.reservoir_valve = item.valve_on;
            end
            OP_EMERGENCY: begin
                // a repeated emergency keeps the first cause
                nx.cannon_valve    = 1'b0;
                nx.reservoir_valve = 1'b0;
                if (state_cur.main_state != ST_EMERG) begin
                    nx.main_state  = ST_EMERG;
                    nx.state_ticks = 16'd0;
                    nx.cause       = CAUSE_EXTERNAL;
                end
            end
            default: ;
        endcase
    end

    assign state_next = nx;

    always_comb begin
        result.main_state_out      = 4'(nx.main_state);
        result.sub_state_out       = 2'(nx.sub_state);
        result.cannon_valve_out    = nx.cannon_valve;
        result.reservoir_valve_out = nx.reservoir_valve;
        result.emergency_cause     = 2'(nx.cause);
        result.last_fill_ticks     = nx.fill_len;
        result.pause_total_ticks   = nx.pause_ticks;
    end

endmodule

// ===== design/irrigation_reel_sequencer_unit.sv =====
// Top level of the hose-reel irrigation sequencer: config registers, request
// register, state register and result register around irs_step.
// Depends on irs_pkg and irs_step.
//
// Usage
//   s_valid/s_ready/s_item carry one request: a 100 ms tick (with sampled
//   pressure, end-of-travel and reservoir-full levels) or an operator command.
//   Each request gives exactly one status result on m_valid/m_ready/m_item,
//   showing the state after that request.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the six settings registers;
//   cfg_ready is always high, indexes beyond the list are ignored. Settings
//   must be written while no request is in flight; the block does not check.
// Timing
//   A request is held in the input register; the state and result registers
//   load from it when the result register is empty or being taken, so a
//   result follows acceptance through the input register and then the result
//   register. One request per cycle is sustained while m_ready stays high: the
//   combinational state update in irs_step is the only loop.
// Reset and stalls
//   aresetn (synchronous, active low) returns to idle with valves off and the
//   settings at their defaults. While m_ready is low the result holds, one
//   further request is still taken into the input register, then s_ready drops.
module irrigation_reel_sequencer_unit
    import irs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  irs_in_t     s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output irs_out_t    m_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    irs_cfg_t   cfg_reg;
    irs_state_t state_reg;
    irs_state_t state_next;
    irs_in_t    in_item_reg;
    logic       in_valid_reg;
    irs_out_t   out_item_reg;
    irs_out_t   out_next;
    logic       out_valid_reg;
    logic       advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_DELAY:   cfg_reg.start_delay_ticks   <= cfg_data;
                CFG_ARRIVAL_DELAY: cfg_reg.arrival_delay_ticks <= cfg_data;
                CFG_DRAIN:         cfg_reg.drain_ticks         <= cfg_data;
                CFG_FILL_TIMEOUT:  cfg_reg.fill_timeout_ticks  <= cfg_data;
                CFG_TIMED_FILL:    cfg_reg.timed_fill_mode     <= cfg_data[0];
                CFG_PROGRAM_VALID: cfg_reg.program_valid       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_item_reg <= s_item;
    end

    irs_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) out_item_reg <= out_next;
    end

    // emergency always reports both valves closed
    a_emerg_valves: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.main_state_out == 4'(ST_EMERG))
            |-> (!m_item.cannon_valve_out && !m_item.reservoir_valve_out))
        else $error("valve open in emergency");

    // a cause is held exactly while in emergency
    a_cause_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.main_state == ST_EMERG) == (state_reg.cause != CAUSE_NONE))
        else $error("emergency cause out of step with state");

    // state only moves when a request passes into the result register
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without a request");

    // a held request is not dropped while the result side stalls
    a_req_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("stalled request lost");

endmodule
